[hw/rtl/bal_pkg.sv]
// Shared types and constants for the bounded array list.
// Used by bal_ram and bounded_array_list; depends on nothing else.
package bal_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CFG_W    = 5;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SET    = 2'd1,
        OP_INSERT = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [INDEX_W-1:0]         item_index;
        logic signed [DATA_W-1:0]   data_value;
    } cmd_t;

    typedef struct packed {
        status_t                    status;
        logic signed [DATA_W-1:0]   old_value;
        logic [FILL_W-1:0]          fill_level;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_OLD,
        ST_SHIFT,
        ST_INS_FINAL
    } state_t;

endpackage

[hw/rtl/bal_ram.sv]
// Entry storage: one write port and one read port with registered read data.
// Depends on bal_pkg for the word width.
module bal_ram #(
    parameter int DEPTH  = bal_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [ADDR_W-1:0]                  waddr,
    input  logic signed [bal_pkg::DATA_W-1:0]  wdata,
    input  logic                               re,
    input  logic [ADDR_W-1:0]                  raddr,
    output logic signed [bal_pkg::DATA_W-1:0]  rdata
);

    logic signed [bal_pkg::DATA_W-1:0] store_mem [DEPTH];
    logic signed [bal_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bounded_array_list.sv]
// Bounded array list: a fixed-capacity list of signed 32-bit words kept in one
// synchronous RAM. A transaction is accepted when start is high and busy is low,
// and its result appears on result for exactly one cycle with result_valid high;
// the receiver cannot stall it, so it must take the result in that cycle.
// Append and every refused or unused opcode finish in the execute state, set
// adds a state that reads the old value, and a successful insert shifts the
// entries above the index up one per cycle through the RAM's single read and
// write port before it writes the new entry. Depends on bal_pkg and bal_ram.
module bounded_array_list #(
    parameter int DEPTH = bal_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bal_pkg::cmd_t             cmd,
    output logic                      result_valid,
    output bal_pkg::rsp_t             result,
    input  logic                      cfg_we,
    input  logic [bal_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > bal_pkg::CFG_W) ? CNT_W : bal_pkg::CFG_W;
    localparam int CMP_W = (CNT_W > bal_pkg::INDEX_W) ? CNT_W : bal_pkg::INDEX_W;

    bal_pkg::state_t             state_reg, state_next;
    bal_pkg::cmd_t               cmd_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            ptr_reg, ptr_next;
    logic [bal_pkg::CFG_W-1:0]   cap_reg;
    logic                        rsp_valid_reg, rsp_valid_next;
    bal_pkg::rsp_t               rsp_reg, rsp_next;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [bal_pkg::DATA_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic signed [bal_pkg::DATA_W-1:0] mem_rdata;

    logic [LIM_W-1:0] limit;
    logic             is_full;
    logic             is_range;
    logic             shift_last;
    logic [AW-1:0]    idx_addr;
    logic [CNT_W-1:0] ptr_dec1;
    logic [CNT_W-1:0] ptr_dec2;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;

    bal_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The limit in force saturates at the storage depth.
    assign limit = (LIM_W'(cap_reg) < LIM_W'(DEPTH)) ? LIM_W'(cap_reg) : LIM_W'(DEPTH);
    assign is_full  = LIM_W'(count_reg) >= limit;
    assign is_range = CMP_W'(cmd_reg.item_index) >= CMP_W'(count_reg);
    assign shift_last = CMP_W'(ptr_reg) == (CMP_W'(cmd_reg.item_index) + CMP_W'(1));
    assign idx_addr  = AW'(cmd_reg.item_index);
    assign ptr_dec1  = ptr_reg - CNT_W'(1);
    assign ptr_dec2  = ptr_reg - CNT_W'(2);
    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bal_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bal_pkg::ST_EXEC;
                end
            end
            bal_pkg::ST_EXEC:
            begin
                state_next = bal_pkg::ST_IDLE;
                if (cmd_reg.opcode == bal_pkg::OP_SET && !is_range)
                begin
                    state_next = bal_pkg::ST_READ_OLD;
                end
                else if (cmd_reg.opcode == bal_pkg::OP_INSERT && !is_full && !is_range)
                begin
                    state_next = bal_pkg::ST_SHIFT;
                end
            end
            bal_pkg::ST_READ_OLD:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
            bal_pkg::ST_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = bal_pkg::ST_INS_FINAL;
                end
            end
            bal_pkg::ST_INS_FINAL:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_addr;
        mem_wdata      = cmd_reg.data_value;
        mem_re         = 1'b0;
        mem_raddr      = idx_addr;

        unique case (state_reg)
            bal_pkg::ST_EXEC:
            begin
                rsp_next.old_value  = '0;
                rsp_next.fill_level = bal_pkg::FILL_W'(count_reg);
                rsp_next.status     = bal_pkg::STATUS_OK;
                unique case (cmd_reg.opcode)
                    bal_pkg::OP_APPEND:
                    begin
                        rsp_valid_next = 1'b1;
                        if (is_full)
                        begin
                            rsp_next.status = bal_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = count_reg[AW-1:0];
                            count_next          = count_inc;
                            rsp_next.fill_level = bal_pkg::FILL_W'(count_inc);
                        end
                    end
                    bal_pkg::OP_SET:
                    begin
                        if (is_range)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = bal_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                    bal_pkg::OP_INSERT:
                    begin
                        if (is_full)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = bal_pkg::STATUS_FULL;
                        end
                        else if (is_range)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = bal_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            // Start the shift at the top: read the last entry.
                            mem_re    = 1'b1;
                            mem_raddr = count_dec[AW-1:0];
                            ptr_next  = count_reg;
                        end
                    end
                    default:
                    begin
                        rsp_valid_next = 1'b1;
                    end
                endcase
            end
            bal_pkg::ST_READ_OLD:
            begin
                mem_we              = 1'b1;
                rsp_valid_next      = 1'b1;
                rsp_next.status     = bal_pkg::STATUS_OK;
                rsp_next.old_value  = mem_rdata;
                rsp_next.fill_level = bal_pkg::FILL_W'(count_reg);
            end
            bal_pkg::ST_SHIFT:
            begin
                // Write the entry read last cycle one place up, and read the next
                // one below it; the two addresses never coincide.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (!shift_last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_dec2[AW-1:0];
                    ptr_next  = ptr_dec1;
                end
            end
            bal_pkg::ST_INS_FINAL:
            begin
                mem_we              = 1'b1;
                count_next          = count_inc;
                rsp_valid_next      = 1'b1;
                rsp_next.status     = bal_pkg::STATUS_OK;
                rsp_next.old_value  = '0;
                rsp_next.fill_level = bal_pkg::FILL_W'(count_inc);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bal_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= bal_pkg::CAPACITY_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy         = (state_reg != bal_pkg::ST_IDLE);
    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

endmodule
